// File: rtl/i2c_tvs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C test vector sequencer.
// No dependencies; imported by every module of the block.
package i2c_tvs_pkg;

  localparam int MAX_BYTES   = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [6:0] DEV_ADDR_RESET = 7'h6B;
  localparam logic       REG_DEVICE_ADDRESS = 1'b0;

  localparam logic [2:0] PIN_LOW    = 3'd0;
  localparam logic [2:0] PIN_HIGH   = 3'd1;
  localparam logic [2:0] PIN_EXP0   = 3'd2;
  localparam logic [2:0] PIN_EXP1   = 3'd3;
  localparam logic [2:0] PIN_IGNORE = 3'd4;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_LAUNCH = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_W    = 4'd1,
    PH_ADDR_W     = 4'd2,
    PH_ACK_ADDR_W = 4'd3,
    PH_CMD        = 4'd4,
    PH_ACK_CMD    = 4'd5,
    PH_WDATA      = 4'd6,
    PH_ACK_WDATA  = 4'd7,
    PH_MID_STOP   = 4'd8,
    PH_START_R    = 4'd9,
    PH_ADDR_R     = 4'd10,
    PH_ACK_ADDR_R = 4'd11,
    PH_RDATA      = 4'd12,
    PH_ACK_OUT    = 4'd13,
    PH_STOP       = 4'd14
  } phase_t;

  typedef struct packed {
    logic        opcode;
    logic        check_mode;
    logic [7:0]  register_byte;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
  } in_word_t;

  typedef struct packed {
    logic [2:0] clock_pin_code;
    logic [2:0] data_pin_code;
    logic       in_transaction;
    logic       transaction_end;
    logic       launch_dropped;
  } out_word_t;

  typedef struct packed {
    logic        is_launch;
    logic        check_mode;
    logic [7:0]  register_byte;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
  } cmd_t;

endpackage

// File: rtl/i2c_tvs_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them into commands and
// queues them for the back end. Depends on i2c_tvs_pkg.
module i2c_tvs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2c_tvs_pkg::in_word_t in_word,
  output logic                  q_valid,
  output i2c_tvs_pkg::cmd_t     q_word,
  input  logic                  q_pop
);
  import i2c_tvs_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  cmd_t              cmd;

  always_comb begin
    cmd.is_launch     = (in_word.opcode == OP_LAUNCH);
    cmd.check_mode    = in_word.check_mode;
    cmd.register_byte = in_word.register_byte;
    cmd.data_word     = in_word.data_word;
    cmd.byte_count    = (in_word.byte_count > 3'(MAX_BYTES)) ? 3'(MAX_BYTES)
                                                             : in_word.byte_count;
  end

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_word   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// File: rtl/i2c_tvs_back.sv
`timescale 1ns / 1ps
// Back end: bit-level I2C sequencer that turns queued commands into pin
// vectors, with the output register. Depends on i2c_tvs_pkg.
module i2c_tvs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [6:0]             dev_addr,
  input  logic                   q_valid,
  input  i2c_tvs_pkg::cmd_t      q_word,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output i2c_tvs_pkg::out_word_t out_word
);
  import i2c_tvs_pkg::*;

  logic [2:0]  clk_pin_r, clk_pin_nxt;
  logic [2:0]  dat_pin_r, dat_pin_nxt;
  logic        busy_r, busy_nxt;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  sub_r, sub_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [7:0]  saved_reg_r, saved_reg_nxt;
  logic        saved_mode_r, saved_mode_nxt;
  logic        dropped_r, dropped_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic        done;
  logic        in_tx;
  logic        tx_end;
  logic [7:0]  cur_byte;
  logic        cur_bit;
  logic [2:0]  bl_dec;
  logic        ack;

  assign q_pop     = q_valid && (q_word.is_launch || !out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    unique case (phase_r)
      PH_ADDR_W: cur_byte = {dev_addr, 1'b0};
      PH_ADDR_R: cur_byte = {dev_addr, 1'b1};
      PH_CMD:    cur_byte = saved_reg_r;
      default:   cur_byte = shift_r[7:0];
    endcase
    cur_bit = cur_byte[3'd7 - bit_r];
    bl_dec  = (bytes_left_r != 3'd0) ? bytes_left_r - 3'd1 : bytes_left_r;
    ack     = (bytes_left_r > 3'd1);
  end

  always_comb begin
    clk_pin_nxt    = clk_pin_r;
    dat_pin_nxt    = dat_pin_r;
    busy_nxt       = busy_r;
    phase_nxt      = phase_r;
    sub_nxt        = sub_r;
    bit_nxt        = bit_r;
    bytes_left_nxt = bytes_left_r;
    shift_nxt      = shift_r;
    saved_reg_nxt  = saved_reg_r;
    saved_mode_nxt = saved_mode_r;
    dropped_nxt    = dropped_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    done           = 1'b0;
    in_tx          = 1'b1;
    tx_end         = 1'b0;

    if (q_pop) begin
      if (q_word.is_launch) begin
        if (busy_r) begin
          dropped_nxt = 1'b1;
        end else begin
          busy_nxt       = 1'b1;
          phase_nxt      = PH_START_W;
          sub_nxt        = 3'd0;
          bit_nxt        = 3'd0;
          saved_mode_nxt = q_word.check_mode;
          saved_reg_nxt  = q_word.register_byte;
          shift_nxt      = q_word.data_word;
          bytes_left_nxt = q_word.byte_count;
        end
      end else begin
        unique case (phase_r)
          PH_START_W, PH_START_R: begin
            if (sub_r == 3'd0) begin
              dat_pin_nxt = PIN_LOW;
            end else begin
              clk_pin_nxt = PIN_LOW;
              dat_pin_nxt = PIN_LOW;
            end
            done = (sub_r >= 3'd1);
            if (done) begin
              phase_nxt = (phase_r == PH_START_W) ? PH_ADDR_W : PH_ADDR_R;
            end
          end
          PH_ADDR_W, PH_ADDR_R, PH_CMD, PH_WDATA: begin
            clk_pin_nxt = (sub_r == 3'd1 || sub_r == 3'd2) ? PIN_HIGH : PIN_LOW;
            dat_pin_nxt = cur_bit ? PIN_HIGH : PIN_LOW;
            done = (sub_r >= 3'd3);
            if (done) begin
              if (bit_r == 3'd7) begin
                bit_nxt   = 3'd0;
                phase_nxt = phase_t'(phase_r + 4'd1);
              end else begin
                bit_nxt = bit_r + 3'd1;
              end
            end
          end
          PH_RDATA: begin
            if (sub_r == 3'd1 || sub_r == 3'd2) begin
              clk_pin_nxt = PIN_HIGH;
              dat_pin_nxt = cur_bit ? PIN_EXP1 : PIN_EXP0;
            end else begin
              clk_pin_nxt = PIN_LOW;
              dat_pin_nxt = PIN_IGNORE;
            end
            done = (sub_r >= 3'd3);
            if (done) begin
              if (bit_r == 3'd7) begin
                bit_nxt   = 3'd0;
                phase_nxt = PH_ACK_OUT;
              end else begin
                bit_nxt = bit_r + 3'd1;
              end
            end
          end
          PH_ACK_ADDR_W, PH_ACK_CMD, PH_ACK_WDATA, PH_ACK_ADDR_R: begin
            if (sub_r == 3'd0) begin
              clk_pin_nxt = PIN_LOW;
              dat_pin_nxt = PIN_IGNORE;
            end else if (sub_r <= 3'd2) begin
              clk_pin_nxt = PIN_HIGH;
              dat_pin_nxt = PIN_EXP0;
            end else begin
              clk_pin_nxt = PIN_LOW;
              dat_pin_nxt = PIN_LOW;
            end
            done = (sub_r >= 3'd3);
            if (done) begin
              unique case (phase_r)
                PH_ACK_ADDR_W: phase_nxt = PH_CMD;
                PH_ACK_CMD: begin
                  if (saved_mode_r) begin
                    phase_nxt = PH_MID_STOP;
                  end else begin
                    phase_nxt = (bytes_left_r != 3'd0) ? PH_WDATA : PH_STOP;
                  end
                end
                PH_ACK_WDATA: begin
                  shift_nxt      = shift_r >> 8;
                  bytes_left_nxt = bl_dec;
                  phase_nxt      = (bl_dec != 3'd0) ? PH_WDATA : PH_STOP;
                end
                default: phase_nxt = (bytes_left_r != 3'd0) ? PH_RDATA : PH_STOP;
              endcase
            end
          end
          PH_ACK_OUT: begin
            if (sub_r <= 3'd1) begin
              clk_pin_nxt = PIN_LOW;
              dat_pin_nxt = ack ? PIN_LOW : PIN_HIGH;
            end else if (sub_r <= 3'd3) begin
              clk_pin_nxt = PIN_HIGH;
              dat_pin_nxt = ack ? PIN_LOW : PIN_HIGH;
            end else begin
              clk_pin_nxt = PIN_LOW;
              dat_pin_nxt = ack ? PIN_IGNORE : PIN_LOW;
            end
            done = (sub_r >= 3'd4);
            if (done) begin
              shift_nxt      = shift_r >> 8;
              bytes_left_nxt = bl_dec;
              phase_nxt      = (bl_dec != 3'd0) ? PH_RDATA : PH_STOP;
            end
          end
          PH_MID_STOP, PH_STOP: begin
            if (sub_r == 3'd0) begin
              dat_pin_nxt = PIN_LOW;
            end else if (sub_r == 3'd1) begin
              clk_pin_nxt = PIN_HIGH;
              dat_pin_nxt = PIN_LOW;
            end else begin
              clk_pin_nxt = PIN_HIGH;
              dat_pin_nxt = PIN_HIGH;
            end
            done = (sub_r >= 3'd2);
            if (done) begin
              if (phase_r == PH_MID_STOP) begin
                phase_nxt = PH_START_R;
              end else begin
                tx_end    = 1'b1;
                busy_nxt  = 1'b0;
                phase_nxt = PH_IDLE;
              end
            end
          end
          default: begin
            in_tx     = 1'b0;
            busy_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
            sub_nxt   = 3'd0;
          end
        endcase
        if (in_tx) begin
          sub_nxt = done ? 3'd0 : sub_r + 3'd1;
        end
        out_valid_nxt                = 1'b1;
        out_word_nxt.clock_pin_code  = clk_pin_nxt;
        out_word_nxt.data_pin_code   = dat_pin_nxt;
        out_word_nxt.in_transaction  = in_tx;
        out_word_nxt.transaction_end = tx_end;
        out_word_nxt.launch_dropped  = dropped_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_pin_r    <= PIN_HIGH;
      dat_pin_r    <= PIN_HIGH;
      busy_r       <= 1'b0;
      phase_r      <= PH_IDLE;
      sub_r        <= 3'd0;
      bit_r        <= 3'd0;
      bytes_left_r <= 3'd0;
      shift_r      <= 32'd0;
      saved_reg_r  <= 8'd0;
      saved_mode_r <= 1'b0;
      dropped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      clk_pin_r    <= clk_pin_nxt;
      dat_pin_r    <= dat_pin_nxt;
      busy_r       <= busy_nxt;
      phase_r      <= phase_nxt;
      sub_r        <= sub_nxt;
      bit_r        <= bit_nxt;
      bytes_left_r <= bytes_left_nxt;
      shift_r      <= shift_nxt;
      saved_reg_r  <= saved_reg_nxt;
      saved_mode_r <= saved_mode_nxt;
      dropped_r    <= dropped_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

// File: rtl/i2c_test_vector_sequencer.sv
`timescale 1ns / 1ps
// I2C test vector sequencer, top level: APB register, front queue, back end.
// Depends on i2c_tvs_pkg, i2c_tvs_front and i2c_tvs_back.
//
// Takes one word per clock. A tick word yields one pin vector word, a
// launch word yields none and loads a write or check-read transaction
// (a launch while a transaction runs is dropped and sets a sticky flag).
// Each word is handled by the back-end sequencer; results appear in the
// cycle after the word leaves the two-entry front queue, so the block
// runs at one word per clock until out_stall backs up the output
// register and then the queue. The device address register at
// byte address 0 is read live and resets to 0x6B.
module i2c_test_vector_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  i2c_tvs_pkg::in_word_t               in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output i2c_tvs_pkg::out_word_t              out_word,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [i2c_tvs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [i2c_tvs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [i2c_tvs_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                cfg_pready
);
  import i2c_tvs_pkg::*;

  logic [6:0] dev_addr_r, dev_addr_nxt;
  logic       cfg_wr;
  logic       reg_hit;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_word;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == REG_DEVICE_ADDRESS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_hit ? {{(CFG_DATA_W - 7){1'b0}}, dev_addr_r} : '0;

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    if (cfg_wr && reg_hit) begin
      dev_addr_nxt = cfg_pwdata[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  i2c_tvs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  i2c_tvs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dev_addr  (dev_addr_r),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
